>>> hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that an implication holds at every clock edge outside reset
`define CHECK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// check that an implication holds in the cycle after its antecedent
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

>>> hdl/lrvi_pkg.sv
// Package: constants, types and command/status structs of the interpolator
package lrvi_pkg;
   localparam int TABLE_DEPTH_DEFAULT = 8;
   localparam logic [23:0] LOG10_2_Q24 = 24'd5050445;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] REGION_CONST = 2'd0;
   localparam logic [1:0] REGION_BELOW = 2'd1;
   localparam logic [1:0] REGION_ABOVE = 2'd2;
   localparam logic [1:0] REGION_INTERP = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NORM, ST_SQUARE, ST_SCALE, ST_ROUND, ST_SEARCH,
      ST_PREP, ST_MUL, ST_DIV, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture accepted item
      logic norm_step;   // one leading-one shift step
      logic square;      // one squaring step
      logic scale;       // multiply by log10(2)
      logic round;       // round to Q8.16
      logic search_step; // visit one table entry
      logic prep;        // form num/den and select case
      logic mul;         // one product term
      logic div_step;    // one quotient bit
      logic out_load;    // move result to output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic norm_done;
      logic square_done;
      logic search_done;
      logic mul_done;
      logic div_done;
      logic is_query;
      logic short_path;  // constant / below / above / zero span
      logic out_busy;
   } status_type;
endpackage

>>> hdl/lrvi_if.sv
// Valid/ready channel interfaces for request, result and register write
interface lrvi_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [2:0] entry_index;
   logic signed [23:0] entry_log_rate;
   logic [31:0] entry_value;
   logic [47:0] shear_rate;
   modport source (output valid, operation, entry_index, entry_log_rate, entry_value,
                   shear_rate, input ready);
   modport sink (input valid, operation, entry_index, entry_log_rate, entry_value,
                 shear_rate, output ready);
endinterface

interface lrvi_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] two_eta_over_rho;
   logic [1:0] region;
   modport source (output valid, two_eta_over_rho, region, input ready);
   modport sink (input valid, two_eta_over_rho, region, output ready);
endinterface

interface lrvi_csr_if;
   logic valid;
   logic ready;
   logic [3:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> hdl/lrvi_ctrl.sv
// Sequencer that steps the datapath through one write or query
module lrvi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lrvi_pkg::status_type   status,
   output lrvi_pkg::cmd_type      cmd
);
   lrvi_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrvi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         lrvi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lrvi_pkg::ST_NORM;
            end
         end
         lrvi_pkg::ST_NORM: begin
            // writes finish at once; queries normalise
            if (!status.is_query) begin
               state_in = lrvi_pkg::ST_IDLE;
            end else if (status.norm_done) begin
               state_in = lrvi_pkg::ST_SQUARE;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         lrvi_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            if (status.square_done) begin
               state_in = lrvi_pkg::ST_SCALE;
            end
         end
         lrvi_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in = lrvi_pkg::ST_ROUND;
         end
         lrvi_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            state_in = lrvi_pkg::ST_SEARCH;
         end
         lrvi_pkg::ST_SEARCH: begin
            if (status.search_done) begin
               state_in = lrvi_pkg::ST_PREP;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         lrvi_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = lrvi_pkg::ST_MUL;
         end
         lrvi_pkg::ST_MUL: begin
            if (status.short_path) begin
               state_in = lrvi_pkg::ST_OUT;
            end else begin
               cmd.mul = 1'b1;
               if (status.mul_done) begin
                  state_in = lrvi_pkg::ST_DIV;
               end
            end
         end
         lrvi_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = lrvi_pkg::ST_OUT;
            end
         end
         lrvi_pkg::ST_OUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in = lrvi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrvi_pkg::ST_IDLE;
         end
      endcase
   end
endmodule

>>> hdl/lrvi_datapath.sv
// Datapath: table store, log unit, search, multiply and serial divide
module lrvi_datapath #(
   parameter int TABLE_DEPTH = lrvi_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lrvi_pkg::cmd_type    cmd,
   output lrvi_pkg::status_type status,
   input  logic                 req_operation,
   input  logic [2:0]           req_entry_index,
   input  logic signed [23:0]   req_entry_log_rate,
   input  logic [31:0]          req_entry_value,
   input  logic [47:0]          req_shear_rate,
   input  logic                 csr_valid,
   input  logic [3:0]           csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_two_eta_over_rho,
   output logic [1:0]           rsp_region
);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // table store
   logic signed [23:0] log_tab_ff [TABLE_DEPTH];
   logic [31:0]        val_tab_ff [TABLE_DEPTH];
   logic [3:0]         count_ff;
   logic [CW-1:0]      n_eff;

   logic               op_ff;
   logic [47:0]        x_ff;       // normalised rate
   logic [5:0]         p_ff;       // leading-one position
   logic [32:0]        m_ff;       // mantissa Q1.31 (with overflow bit)
   logic [29:0]        frac_ff;
   logic [4:0]         sq_cnt_ff;
   logic               neg_ff;
   logic [59:0]        prod_ff;    // |L2| * log10(2)
   logic signed [24:0] l_ff;       // log10 rate Q8.16
   logic [IW-1:0]      idx_ff;
   logic               sdone_ff;
   logic               zero_ff;
   logic               short_ff;
   logic [1:0]         region_ff;
   logic [31:0]        res_ff;
   logic [24:0]        num_ff, den_ff;
   logic [31:0]        vlo_ff, vhi_ff;
   logic [57:0]        acc_ff;
   logic               mcnt_ff;
   logic [57:0]        rem_ff;
   logic [31:0]        quo_ff;
   logic [5:0]         dcnt_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_val_ff;
   logic [1:0]         rsp_reg_ff;

   always_comb begin
      if (count_ff == 4'd0) begin
         n_eff = CW'(1);
      end else if (32'(count_ff) > TABLE_DEPTH) begin
         n_eff = CW'(TABLE_DEPTH);
      end else begin
         n_eff = CW'(count_ff);
      end
   end

   // register and table writes
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd1;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_operation == lrvi_pkg::OP_WRITE &&
          32'(req_entry_index) < TABLE_DEPTH) begin
         log_tab_ff[IW'(req_entry_index)] <= req_entry_log_rate;
         val_tab_ff[IW'(req_entry_index)] <= req_entry_value;
      end
   end

   // table reads at the search pointer
   logic [IW-1:0]      ilo;
   logic signed [24:0] t_cur, t_lo, t_last;
   assign ilo    = idx_ff - IW'(1);
   assign t_cur  = 25'(log_tab_ff[idx_ff]);
   assign t_lo   = 25'(log_tab_ff[ilo]);
   assign t_last = 25'(log_tab_ff[IW'(n_eff - CW'(1))]);

   // squaring step
   logic [65:0] sq;
   assign sq = 66'(m_ff[31:0]) * 66'(m_ff[31:0]);
   logic [32:0] sq_m;
   assign sq_m = 33'(sq >> 31);

   // log2 in Q.30 from leading-one position and fraction, and its magnitude
   localparam logic [23:0] LOG10_SCALE = lrvi_pkg::LOG10_2_Q24;
   logic signed [37:0] l2;
   logic               l2_neg;
   logic [35:0]        mag_abs;
   assign l2      = ((38'($signed({1'b0, p_ff})) - 38'sd16) <<< 30) +
                    $signed({8'd0, frac_ff});
   assign l2_neg  = l2[37];
   assign mag_abs = l2_neg ? 36'(-l2) : 36'(l2);

   logic [24:0] rounded;
   assign rounded = 25'((prod_ff + (60'd1 << 37)) >> 38);

   // log unit, search and interpolation registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         x_ff     <= req_shear_rate;
         zero_ff  <= (req_shear_rate == 48'd0);
         p_ff     <= 6'd47;
         frac_ff  <= '0;
         sq_cnt_ff <= '0;
         idx_ff   <= IW'(1);
         sdone_ff <= 1'b0;
         mcnt_ff  <= 1'b0;
         dcnt_ff  <= '0;
      end
      if (cmd.norm_step) begin
         x_ff <= {x_ff[46:0], 1'b0};
         p_ff <= p_ff - 6'd1;
      end
      if (cmd.square) begin
         if (sq_cnt_ff == 5'd0) begin
            m_ff <= {1'b0, x_ff[47:16]};
            sq_cnt_ff <= 5'd1;
         end else begin
            sq_cnt_ff <= sq_cnt_ff + 5'd1;
            if (sq_m[32]) begin
               m_ff    <= {1'b0, sq_m[32:1]};
               frac_ff <= {frac_ff[28:0], 1'b1};
            end else begin
               m_ff    <= sq_m;
               frac_ff <= {frac_ff[28:0], 1'b0};
            end
         end
      end
      if (cmd.scale) begin
         prod_ff <= 60'(mag_abs) * 60'(LOG10_SCALE);
         neg_ff  <= l2_neg;
      end
      if (cmd.round) begin
         l_ff <= neg_ff ? -rounded : rounded;
      end
      if (cmd.search_step) begin
         if (32'(idx_ff) + 1 >= 32'(n_eff) - 1 + 1 || l_ff <= t_cur ||
             32'(idx_ff) + 1 >= 32'(n_eff)) begin
            sdone_ff <= 1'b1;
         end else begin
            idx_ff <= idx_ff + IW'(1);
         end
      end
      if (cmd.prep) begin
         short_ff <= 1'b1;
         if (n_eff == CW'(1) || zero_ff) begin
            res_ff <= val_tab_ff[0];
            region_ff <= lrvi_pkg::REGION_CONST;
         end else if (l_ff < 25'(log_tab_ff[0])) begin
            res_ff <= val_tab_ff[0];
            region_ff <= lrvi_pkg::REGION_BELOW;
         end else if (l_ff > t_last) begin
            res_ff <= val_tab_ff[IW'(n_eff - CW'(1))];
            region_ff <= lrvi_pkg::REGION_ABOVE;
         end else begin
            region_ff <= lrvi_pkg::REGION_INTERP;
            if (t_cur - t_lo <= 25'sd0) begin
               res_ff <= val_tab_ff[idx_ff];
            end else begin
               short_ff <= 1'b0;
            end
         end
         den_ff <= 25'(t_cur - t_lo);
         num_ff <= (t_cur - l_ff < 0) ? 25'd0 :
                   ((t_cur - l_ff > t_cur - t_lo) ? 25'(t_cur - t_lo) : 25'(t_cur - l_ff));
         vlo_ff <= val_tab_ff[ilo];
         vhi_ff <= val_tab_ff[idx_ff];
      end
      if (cmd.mul) begin
         mcnt_ff <= 1'b1;
         if (!mcnt_ff) begin
            acc_ff <= 58'(vlo_ff) * 58'(num_ff);
         end else begin
            acc_ff <= acc_ff + 58'(vhi_ff) * 58'(den_ff - num_ff);
            rem_ff <= '0;
         end
      end
      if (cmd.div_step) begin
         // restoring divide, one quotient bit per cycle over 58 bits
         dcnt_ff <= dcnt_ff + 6'd1;
         if ({rem_ff[56:0], acc_ff[57]} >= 58'(den_ff)) begin
            rem_ff <= {rem_ff[56:0], acc_ff[57]} - 58'(den_ff);
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[56:0], acc_ff[57]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
         acc_ff <= {acc_ff[56:0], 1'b0};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_val_ff <= short_ff ? res_ff : quo_ff;
         rsp_reg_ff <= region_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_two_eta_over_rho = rsp_val_ff;
   assign rsp_region           = rsp_reg_ff;

   assign status.norm_done   = x_ff[47] || zero_ff;
   assign status.square_done = (sq_cnt_ff == 5'd30);
   assign status.search_done = sdone_ff || n_eff <= CW'(2);
   assign status.mul_done    = mcnt_ff;
   assign status.div_done    = (dcnt_ff == 6'd57);
   assign status.is_query    = op_ff;
   assign status.short_path  = short_ff;
   assign status.out_busy    = rsp_valid_ff && !rsp_ready;
endmodule

>>> hdl/log_rate_viscosity_interpolator_unit.sv
// Top level of the log-rate viscosity interpolator
//  channel | dir | contents
//  req     | in  | write entry or query a shear rate
//  rsp     | out | interpolated value and region, one per query
//  csr     | in  | entry_count register write
// A write item is stored in the table and gives no result. A query runs:
// accept, leading-one shift, squaring, scale and round, the table search,
// prep, and on an interpolated span the multiply and divide steps, then the
// load of the output register once that register is free.
// Synchronous reset clears the controller and output valid and sets entry_count to 1.
// One item is worked at a time; a stalled result holds in the output register.
module log_rate_viscosity_interpolator_unit #(
   parameter int TABLE_DEPTH = lrvi_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   lrvi_req_if.sink   req,
   lrvi_rsp_if.source rsp,
   lrvi_csr_if.sink   csr
);
   lrvi_pkg::cmd_type    cmd;
   lrvi_pkg::status_type status;

   assign csr.ready = 1'b1;

   lrvi_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .status(status), .cmd(cmd)
   );

   lrvi_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_operation(req.operation), .req_entry_index(req.entry_index),
      .req_entry_log_rate(req.entry_log_rate), .req_entry_value(req.entry_value),
      .req_shear_rate(req.shear_rate), .csr_valid(csr.valid), .csr_data(csr.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_two_eta_over_rho(rsp.two_eta_over_rho), .rsp_region(rsp.region)
   );
endmodule

>>> hdl/lrvi_checker.sv
// Port-level checker for the interpolator, bound to the top level
`include "assert_macros.svh"
module lrvi_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [31:0] rsp_two_eta_over_rho
);
   `CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CHECK_NEXT(a_data_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_two_eta_over_rho))
   `CHECK_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `CHECK_NEXT(a_no_rsp_right_after, clock, reset, req_valid && req_ready && !rsp_valid, !rsp_valid)
endmodule

bind log_rate_viscosity_interpolator_unit lrvi_checker u_lrvi_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_two_eta_over_rho(rsp.two_eta_over_rho)
);
